// ----- hdl/bpm_pkg.sv -----
// bpm_pkg: shared types, codes and defaults of the bracket pair matcher.
// Used by every module in hdl/ except bpm_ram. Depends on nothing.
package bpm_pkg;

    localparam int STACK_DEPTH_DEF  = 64;
    localparam int MAX_TOKENS_DEF   = 65536;
    localparam int PAIR_CLASSES_DEF = 8;

    localparam int KIND_W   = 2;
    localparam int CLS_W    = 3;
    localparam int IDX_W    = 16;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = IDX_W + CLS_W;

    localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_OPENER = 3'd1,
        ST_MISMATCH  = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_HALTED    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    // One classified token handed from the front to the back.
    typedef struct packed {
        logic             restart;
        op_t              op;
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] idx;
    } tok_t;

    // One stack entry: opener number above its class.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CLS_W-1:0] cls;
    } entry_t;

endpackage

// ----- hdl/bpm_ram.sv -----
// bpm_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ----- hdl/bpm_front.sv -----
// bpm_front: accepts tokens, numbers them and classifies them into stack ops.
// Depends on bpm_pkg.
module bpm_front #(
    parameter int MAX_TOKENS   = bpm_pkg::MAX_TOKENS_DEF,
    parameter int PAIR_CLASSES = bpm_pkg::PAIR_CLASSES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_restart,
    input  logic [bpm_pkg::KIND_W-1:0]  s_token_kind,
    input  logic [bpm_pkg::CLS_W-1:0]   s_pair_class,
    output logic                        q_valid,
    input  logic                        q_ready,
    output bpm_pkg::tok_t               q_tok
);

    localparam int CLOG_T = $clog2(MAX_TOKENS);
    localparam int TNW    = (CLOG_T > bpm_pkg::IDX_W) ? CLOG_T : bpm_pkg::IDX_W;
    localparam logic [TNW-1:0] LAST_NUM = TNW'(MAX_TOKENS - 1);

    logic [TNW-1:0] num_reg, num_next, num_cur;
    logic           class_ok;

    assign s_ready  = q_ready;
    assign q_valid  = s_valid;
    assign num_cur  = s_restart ? '0 : num_reg;
    assign class_ok = (32'(s_pair_class) < PAIR_CLASSES);

    always_comb begin
        q_tok.restart = s_restart;
        q_tok.cls     = s_pair_class;
        q_tok.idx     = num_cur[bpm_pkg::IDX_W-1:0];
        if (class_ok && s_token_kind == bpm_pkg::KIND_OPEN) begin
            q_tok.op = bpm_pkg::OP_OPEN;
        end else if (class_ok && s_token_kind == bpm_pkg::KIND_CLOSE) begin
            q_tok.op = bpm_pkg::OP_CLOSE;
        end else begin
            q_tok.op = bpm_pkg::OP_NONE;
        end
        num_next = (num_cur == LAST_NUM) ? '0 : num_cur + TNW'(1);
    end

    // Advance numbering on every accepted token.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= '0;
        end else if (s_valid && s_ready) begin
            num_reg <= num_next;
        end
    end

endmodule

// ----- hdl/bpm_queue.sv -----
// bpm_queue: two-entry register queue between front and back.
// Depends on bpm_pkg.
module bpm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bpm_pkg::tok_t in_tok,
    output logic          out_valid,
    input  logic          out_ready,
    output bpm_pkg::tok_t out_tok
);

    bpm_pkg::tok_t slot_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic          push, pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_tok   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- hdl/bpm_back.sv -----
// bpm_back: executes stack ops, tracks the halt flag, drives the result register.
// Depends on bpm_pkg and bpm_ram.
module bpm_back #(
    parameter int STACK_DEPTH = bpm_pkg::STACK_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  bpm_pkg::tok_t                q_tok,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_pair_found,
    output logic [bpm_pkg::IDX_W-1:0]    m_open_index,
    output logic [bpm_pkg::IDX_W-1:0]    m_close_index,
    output logic [bpm_pkg::STATUS_W-1:0] m_status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [CW-1:0]    count_reg, count_next, count_eff, rd_sub, wr_sub;
    logic             halted_reg, halted_next, halted_eff;
    bpm_pkg::entry_t  top_reg, top_next, byp_reg, byp_next, below_cur, ram_q;
    logic             sel_byp_reg, sel_byp_next;
    logic             fire, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;

    logic                   found_next;
    logic [bpm_pkg::IDX_W-1:0] open_next;
    bpm_pkg::status_t       status_next;

    assign q_ready   = !m_valid || m_ready;
    assign fire      = q_valid && q_ready;
    assign below_cur = sel_byp_reg ? byp_reg : ram_q;
    assign rd_addr   = rd_sub[AW-1:0];
    assign wr_addr   = wr_sub[AW-1:0];

    // Stack entries below the top live in RAM; the top is held in top_reg.
    bpm_ram #(
        .WIDTH(bpm_pkg::ENTRY_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(top_reg),
        .rd_addr(rd_addr),
        .rd_data(ram_q)
    );

    always_comb begin
        count_eff    = (fire && q_tok.restart) ? '0 : count_reg;
        halted_eff   = (fire && q_tok.restart) ? 1'b0 : halted_reg;
        count_next   = count_eff;
        halted_next  = halted_eff;
        top_next     = top_reg;
        byp_next     = byp_reg;
        sel_byp_next = 1'b0;
        rd_sub       = count_eff - CW'(2);
        wr_sub       = count_eff - CW'(1);
        wr_en        = 1'b0;
        found_next   = 1'b0;
        open_next    = '0;
        status_next  = bpm_pkg::ST_OK;
        if (fire) begin
            if (halted_eff) begin
                status_next = bpm_pkg::ST_HALTED;
            end else begin
                unique case (q_tok.op)
                    bpm_pkg::OP_OPEN: begin
                        open_next = q_tok.idx;
                        if (count_eff == CW'(STACK_DEPTH)) begin
                            status_next = bpm_pkg::ST_OVERFLOW;
                            halted_next = 1'b1;
                        end else begin
                            // Spill old top to RAM, keep a copy as the new below-top.
                            wr_en        = (count_eff != '0);
                            top_next     = '{idx: q_tok.idx, cls: q_tok.cls};
                            byp_next     = top_reg;
                            sel_byp_next = 1'b1;
                            count_next   = count_eff + CW'(1);
                        end
                    end
                    bpm_pkg::OP_CLOSE: begin
                        if (count_eff == '0) begin
                            status_next = bpm_pkg::ST_NO_OPENER;
                            halted_next = 1'b1;
                        end else begin
                            open_next  = top_reg.idx;
                            top_next   = below_cur;
                            count_next = count_eff - CW'(1);
                            rd_sub     = count_eff - CW'(3);
                            if (top_reg.cls == q_tok.cls) begin
                                found_next = 1'b1;
                            end else begin
                                status_next = bpm_pkg::ST_MISMATCH;
                                halted_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        byp_reg     <= byp_next;
        sel_byp_reg <= sel_byp_next;
        if (fire) begin
            m_pair_found  <= found_next;
            m_open_index  <= open_next;
            m_close_index <= q_tok.idx;
            m_status      <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            halted_reg <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            count_reg  <= count_next;
            halted_reg <= halted_next;
            if (fire) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/bracket_pair_matcher.sv -----
// Bracket pair matcher: one token per request, one result per token.
// Throughput: one token per cycle, sustained, with the result side ready.
// A token passes through the queue slot and then the result register before its result is valid.
// Reset: synchronous active-low aresetn clears numbering, stack count, halt flag,
// queue and result valid; the stack RAM is not cleared and needs no clearing pass.
// Depends on bpm_pkg, bpm_front, bpm_queue, bpm_back, bpm_ram.
module bracket_pair_matcher #(
    parameter int STACK_DEPTH  = bpm_pkg::STACK_DEPTH_DEF,
    parameter int MAX_TOKENS   = bpm_pkg::MAX_TOKENS_DEF,
    parameter int PAIR_CLASSES = bpm_pkg::PAIR_CLASSES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_restart,
    input  logic [bpm_pkg::KIND_W-1:0]   s_token_kind,
    input  logic [bpm_pkg::CLS_W-1:0]    s_pair_class,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_pair_found,
    output logic [bpm_pkg::IDX_W-1:0]    m_open_index,
    output logic [bpm_pkg::IDX_W-1:0]    m_close_index,
    output logic [bpm_pkg::STATUS_W-1:0] m_status
);

    // Front to queue, queue to back.
    logic          fq_valid, fq_ready;
    bpm_pkg::tok_t fq_tok;
    logic          qb_valid, qb_ready;
    bpm_pkg::tok_t qb_tok;

    // Number each request and turn it into a push, a pop or nothing.
    bpm_front #(
        .MAX_TOKENS  (MAX_TOKENS),
        .PAIR_CLASSES(PAIR_CLASSES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .s_token_kind(s_token_kind),
        .s_pair_class(s_pair_class),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_tok       (fq_tok)
    );

    // Hold up to two classified tokens so front and back stall independently.
    bpm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_tok   (fq_tok),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_tok  (qb_tok)
    );

    // Apply the op to the stack; the top entry sits in a register and the
    // entry under it is prefetched from RAM, so pops can follow every cycle while the result side is ready.
    bpm_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_tok        (qb_tok),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pair_found (m_pair_found),
        .m_open_index (m_open_index),
        .m_close_index(m_close_index),
        .m_status     (m_status)
    );

endmodule

// ----- tb/sv/tb_bracket_pair_matcher.sv -----
// tb_bracket_pair_matcher: self-checking testbench of the bracket pair matcher.
// Predicts every result from its own copy of the stack and checks it in order.
// Depends on bpm_pkg and bracket_pair_matcher.
`timescale 1ns / 1ps

module tb_bracket_pair_matcher;
    import bpm_pkg::*;

    localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
    localparam int MAX_TOKENS   = MAX_TOKENS_DEF;
    localparam int PAIR_CLASSES = PAIR_CLASSES_DEF;
    localparam int SP_W         = $clog2(STACK_DEPTH);

    // Token kinds that the package leaves unnamed: a plain token and the spare code.
    localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int ITEM_TARGET  = 1900;
    localparam int IDLE_PCT     = 11;
    localparam int QUIET_FROM   = 700;   // no idling on either side in this request window
    localparam int QUIET_TO     = 1100;
    localparam int STUCK_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 10;
    localparam int SHOW_ERRORS  = 10;

    typedef struct packed {
        logic              restart;
        logic [KIND_W-1:0] kind;
        logic [CLS_W-1:0]  cls;
    } token_req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] open_idx;
        logic [IDX_W-1:0] close_idx;
        status_t          status;
    } match_result_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic                s_restart     = 1'b0;
    logic [KIND_W-1:0]   s_token_kind  = KIND_PLAIN;
    logic [CLS_W-1:0]    s_pair_class  = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_pair_found;
    logic [IDX_W-1:0]    m_open_index;
    logic [IDX_W-1:0]    m_close_index;
    logic [STATUS_W-1:0] m_status;

    bracket_pair_matcher #(
        .STACK_DEPTH  (STACK_DEPTH),
        .MAX_TOKENS   (MAX_TOKENS),
        .PAIR_CLASSES (PAIR_CLASSES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .s_token_kind  (s_token_kind),
        .s_pair_class  (s_pair_class),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pair_found  (m_pair_found),
        .m_open_index  (m_open_index),
        .m_close_index (m_close_index),
        .m_status      (m_status)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted matcher state: opener stack, its fill level, the running
    // token number and the halt flag.
    // ------------------------------------------------------------------
    entry_t      opener_stack [STACK_DEPTH];
    int          open_depth  = 0;
    int unsigned next_token  = 0;
    logic        matching_off = 1'b0;

    token_req_t    pending_tokens[$];     // requests not yet driven
    match_result_t predicted_results[$];  // results owed by the block, oldest first

    int tokens_sent  = 0;
    int results_seen = 0;
    int errors       = 0;
    int stuck_cycles = 0;

    // Work out the result of one token and advance the predicted state.
    function automatic match_result_t predict_match(token_req_t t);
        match_result_t r;
        int unsigned   me;
        entry_t        top;
        r.found    = 1'b0;
        r.open_idx = '0;
        r.status   = ST_OK;
        if (t.restart) begin
            open_depth   = 0;
            next_token   = 0;
            matching_off = 1'b0;
        end
        me          = next_token;
        next_token  = (next_token + 1) % MAX_TOKENS;
        r.close_idx = me[IDX_W-1:0];
        if (matching_off) begin
            r.status = ST_HALTED;
        end else if ((t.kind == KIND_OPEN || t.kind == KIND_CLOSE)
                     && int'(t.cls) < PAIR_CLASSES) begin
            if (t.kind == KIND_OPEN) begin
                r.open_idx = me[IDX_W-1:0];
                if (open_depth >= STACK_DEPTH) begin
                    r.status     = ST_OVERFLOW;
                    matching_off = 1'b1;
                end else begin
                    top.idx = me[IDX_W-1:0];
                    top.cls = t.cls;
                    opener_stack[open_depth[SP_W-1:0]] = top;
                    open_depth++;
                end
            end else if (open_depth == 0) begin
                r.status     = ST_NO_OPENER;
                matching_off = 1'b1;
            end else begin
                open_depth--;
                top        = opener_stack[open_depth[SP_W-1:0]];
                r.open_idx = top.idx;
                if (top.cls == t.cls) begin
                    r.found = 1'b1;
                end else begin
                    r.status     = ST_MISMATCH;
                    matching_off = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic void note_error(string msg);
        errors++;
        if (errors <= SHOW_ERRORS)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Token stream generator. It keeps its own view of the open classes so
    // that most sequences are well nested and get deep into the stack.
    // ------------------------------------------------------------------
    logic [CLS_W-1:0] gen_open[$];
    bit               gen_need_restart = 1'b1;
    bit               gen_restart_armed = 1'b0;

    task automatic put_token(input bit rst, input logic [KIND_W-1:0] kind,
                             input logic [CLS_W-1:0] cls);
        token_req_t t;
        t.restart = rst;
        t.kind    = kind;
        t.cls     = cls;
        pending_tokens.insert(pending_tokens.size(), t);
    endtask

    // Emit one token, carrying a pending restart if one is armed.
    task automatic gen_token(input logic [KIND_W-1:0] kind, input logic [CLS_W-1:0] cls);
        put_token(gen_restart_armed, kind, cls);
        gen_restart_armed = 1'b0;
    endtask

    task automatic gen_noise();
        logic [KIND_W-1:0] kind;
        kind = ($urandom_range(0, 1) == 0) ? KIND_PLAIN : KIND_SPARE;
        // Now and then restart in the middle of a sequence.
        if ($urandom_range(0, 49) == 0) begin
            gen_restart_armed = 1'b1;
            gen_need_restart  = 1'b0;
            gen_open.delete();
        end
        gen_token(kind, CLS_W'($urandom_range(0, 7)));
    endtask

    task automatic gen_open_tok();
        logic [CLS_W-1:0] cls;
        cls = CLS_W'($urandom_range(0, 7));
        gen_token(KIND_OPEN, cls);
        gen_open.insert(gen_open.size(), cls);
    endtask

    task automatic gen_close_tok();
        logic [CLS_W-1:0] cls;
        cls = gen_open[$];
        gen_open.delete(gen_open.size() - 1);
        gen_token(KIND_CLOSE, cls);
    endtask

    // Random tokens after an error; the block answers them as halted.
    task automatic gen_tail();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) gen_token(KIND_W'($urandom_range(0, 3)), CLS_W'($urandom_range(0, 7)));
        gen_need_restart = 1'b1;
    endtask

    task automatic gen_start(input bit must_restart);
        if (must_restart || gen_need_restart || $urandom_range(0, 9) < 7) begin
            gen_restart_armed = 1'b1;
            gen_need_restart  = 1'b0;
            gen_open.delete();
        end
    endtask

    task automatic gen_well_formed();
        int len;
        int deep;
        int open_pct;
        int r;
        deep     = ($urandom_range(0, 19) == 0) ? STACK_DEPTH : $urandom_range(1, 10);
        len      = (deep == STACK_DEPTH) ? $urandom_range(120, 160) : $urandom_range(4, 40);
        open_pct = (deep == STACK_DEPTH) ? 75 : 45;
        gen_start(deep == STACK_DEPTH);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                gen_noise();
            else if (gen_open.size() < deep && (gen_open.size() == 0 || r < 12 + open_pct))
                gen_open_tok();
            else
                gen_close_tok();
        end
        // Mostly close everything; otherwise leave openers for the next restart.
        if ($urandom_range(0, 4) == 0 && gen_open.size() != 0)
            gen_need_restart = 1'b1;
        else
            while (gen_open.size() != 0) gen_close_tok();
    endtask

    task automatic gen_mismatch();
        int n;
        logic [CLS_W-1:0] cls;
        gen_start(1'b0);
        n = $urandom_range(1, 6);
        repeat (n) gen_open_tok();
        if ($urandom_range(0, 1) == 0) begin
            gen_open_tok();
            gen_close_tok();
        end
        cls = gen_open[$] ^ 3'($urandom_range(1, 7));
        gen_token(KIND_CLOSE, cls);
        gen_tail();
    endtask

    task automatic gen_overflow();
        gen_start(1'b1);
        repeat (STACK_DEPTH + 1) gen_open_tok();
        gen_tail();
    endtask

    task automatic gen_lonely_close();
        int n;
        gen_start(1'b0);
        n = $urandom_range(0, 3);
        repeat (n) begin
            gen_open_tok();
            gen_close_tok();
        end
        gen_token(KIND_CLOSE, CLS_W'($urandom_range(0, 7)));
        gen_tail();
    endtask

    task automatic gen_junk();
        int n;
        gen_start(1'b0);
        n = $urandom_range(5, 20);
        repeat (n) put_token($urandom_range(0, 9) == 0, KIND_W'($urandom_range(0, 3)),
                             CLS_W'($urandom_range(0, 7)));
        gen_restart_armed = 1'b0;
        gen_need_restart  = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next request whenever the channel is free, idling
    // now and then. Predict each request at the edge that accepts it.
    // ------------------------------------------------------------------
    wire quiet = tokens_sent >= QUIET_FROM && tokens_sent < QUIET_TO;

    always @(posedge aclk) begin
        token_req_t t;
        token_req_t held;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                held.restart = s_restart;
                held.kind    = s_token_kind;
                held.cls     = s_pair_class;
                predicted_results.insert(predicted_results.size(), predict_match(held));
                tokens_sent <= tokens_sent + 1;
            end
            // Hold the payload while the request is waiting; otherwise load the next one.
            if (!s_valid || s_ready) begin
                if (pending_tokens.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    t = pending_tokens.pop_front();
                    s_valid      <= 1'b1;
                    s_restart    <= t.restart;
                    s_token_kind <= t.kind;
                    s_pair_class <= t.cls;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side at random, except in the quiet window.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        match_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (predicted_results.size() == 0) begin
                note_error($sformatf("result %0d with nothing predicted: close %0d status %0d",
                                     results_seen, m_close_index, m_status));
            end else begin
                want = predicted_results.pop_front();
                if (m_pair_found !== want.found || m_open_index !== want.open_idx
                    || m_close_index !== want.close_idx || m_status !== want.status)
                    note_error($sformatf({"result %0d mismatch (expected/actual): found %0d/%0d ",
                                          "open %0d/%0d close %0d/%0d status %0d/%0d"},
                                         results_seen, want.found, m_pair_found,
                                         want.open_idx, m_open_index,
                                         want.close_idx, m_close_index,
                                         want.status, m_status));
            end
        end
    end

    // Watchdog: end the run if no handshake happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("tb_bracket_pair_matcher: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int pick;
        int total_tokens;

        // Directed: plain and spare tokens, every class nested and closed in
        // order, a closer with an empty stack, a halted opener, a class
        // mismatch and a halted closer, each cleared by a restart.
        put_token(1'b1, KIND_PLAIN, 3'd7);
        put_token(1'b0, KIND_SPARE, 3'd5);
        for (int c = 0; c < 8; c++) put_token(1'b0, KIND_OPEN, CLS_W'(c));
        for (int c = 7; c >= 0; c--) put_token(1'b0, KIND_CLOSE, CLS_W'(c));
        put_token(1'b0, KIND_CLOSE, 3'd0);
        put_token(1'b0, KIND_OPEN, 3'd1);
        put_token(1'b1, KIND_OPEN, 3'd3);
        put_token(1'b0, KIND_CLOSE, 3'd4);
        put_token(1'b0, KIND_CLOSE, 3'd3);
        put_token(1'b1, KIND_PLAIN, 3'd0);
        gen_need_restart = 1'b0;

        // Random: mostly well-nested sequences, the rest broken ones and noise.
        while (pending_tokens.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                gen_well_formed();
            else if (pick < 80)
                gen_mismatch();
            else if (pick < 84)
                gen_overflow();
            else if (pick < 90)
                gen_lonely_close();
            else
                gen_junk();
        end
        total_tokens = pending_tokens.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for one result per request, then watch for strays.
        @(posedge aclk);
        while (results_seen < total_tokens)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (predicted_results.size() != 0)
            note_error($sformatf("%0d predicted results never arrived", predicted_results.size()));

        if (errors == 0)
            $display("tb_bracket_pair_matcher: PASS");
        else
            $display("tb_bracket_pair_matcher: FAIL");
        $finish;
    end

endmodule
